// ----- src/vda_pkg.sv -----
// Shared types and constants for the video degradation adapter.
// No dependencies; imported by vda_ctrl, vda_datapath and the core top level.
package vda_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_DISABLED   = 2'd0;
    localparam logic [1:0] MODE_FRAMERATE  = 2'd1;  // keeps fps, degrades resolution
    localparam logic [1:0] MODE_RESOLUTION = 2'd2;  // keeps resolution, degrades fps
    localparam logic [1:0] MODE_BALANCED   = 2'd3;  // treated as framerate mode
    localparam int unsigned MODE_W = 2;
    localparam int unsigned NUM_MODES = 4;

    // Request codes
    localparam logic OP_DOWN        = 1'b0;
    localparam logic OP_UP          = 1'b1;
    localparam logic REASON_QUALITY = 1'b0;
    localparam logic REASON_CPU     = 1'b1;

    // Field widths
    localparam int unsigned PC_W    = 22;
    localparam int unsigned FPS_W   = 8;
    localparam int unsigned PIX_W   = 24;
    localparam int unsigned LFPS_W  = 10;
    localparam int unsigned STEPS_W = 8;

    // Limits and steps
    localparam logic [STEPS_W-1:0] MAX_RES_DOWNGRADES = 8'd2;
    localparam logic [STEPS_W-1:0] MAX_FPS_DOWNGRADES = 8'd4;
    localparam logic [STEPS_W-1:0] STEPS_FULL         = 8'd255;
    localparam logic [PC_W-1:0]    MIN_PIXELS         = 22'd57600;
    localparam logic [FPS_W-1:0]   MIN_FPS            = 8'd2;
    localparam logic [PIX_W-1:0]   PIX_UNLIM          = 24'hFF_FFFF;
    localparam logic [LFPS_W-1:0]  FPS_UNLIM          = 10'd1023;

    // Reciprocal multipliers: x*K >> shift is exact over the full input range
    localparam int unsigned   RECIP_SHIFT = 26;
    localparam logic [25:0]   K_PIX_3_5   = 26'd40265319;   // 3 * ceil(2^26/5)
    localparam logic [26:0]   K_PIX_5_3   = 27'd111848110;  // 5 * ceil(2^26/3)
    localparam int unsigned   FPS_SHIFT   = 10;
    localparam logic [9:0]    K_FPS_2_3   = 10'd684;        // 2 * ceil(2^10/3)

    typedef enum logic [0:0] {
        S_IDLE,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic load;   // latch the request and its products
        logic apply;  // update state and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic [STEPS_W-1:0] quality;
        logic [STEPS_W-1:0] cpu;
    } t_step_pair;

endpackage

// ----- src/video_degradation_adapter_core.sv -----
// Video degradation adapter: top level joining controller and datapath.
// Depends on vda_pkg, vda_ctrl and vda_datapath.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries one adapt-down or
//   adapt-up request per beat with its reason, frame pixel count and fps.
//   Result channel (o_out_valid / i_out_ready) returns exactly one beat per
//   request: acted flag, mode-masked pixel/target/fps limits, step counts.
//   The mode register is written through i_cfg_we / i_cfg_wdata; the user
//   must write it only while idle, as the block does not enforce it.
// Timing:
//   A request is taken in the cycle it is offered while the block is idle;
//   its scaling products are registered on the accepting edge, then the state
//   is updated and the result register loaded once the output is free, and
//   only then is the next request taken. A result waiting at the output does
//   not block acceptance; the block holds in its update state only if the
//   previous result is still unclaimed when the next one is ready.
// Reset: synchronous, active low; counters cleared, limits unlimited,
//   mode disabled, no result pending.
module video_degradation_adapter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vda_pkg::MODE_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic                         i_reason,
    input  logic [vda_pkg::PC_W-1:0]     i_pixel_count,
    input  logic [vda_pkg::FPS_W-1:0]    i_framerate_fps,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_acted,
    output logic [vda_pkg::PIX_W-1:0]    o_max_pixels,
    output logic [vda_pkg::PIX_W-1:0]    o_target_pixels,
    output logic                         o_target_valid,
    output logic [vda_pkg::LFPS_W-1:0]   o_max_fps,
    output logic [vda_pkg::STEPS_W-1:0]  o_quality_steps,
    output logic [vda_pkg::STEPS_W-1:0]  o_cpu_steps
);
    import vda_pkg::*;

    t_dp_cmd cmd;

    vda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    vda_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_operation),
        .i_reason        (i_reason),
        .i_pixel_count   (i_pixel_count),
        .i_framerate_fps (i_framerate_fps),
        .o_acted         (o_acted),
        .o_max_pixels    (o_max_pixels),
        .o_target_pixels (o_target_pixels),
        .o_target_valid  (o_target_valid),
        .o_max_fps       (o_max_fps),
        .o_quality_steps (o_quality_steps),
        .o_cpu_steps     (o_cpu_steps)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while previous one still in update");

    // with the output free, a taken request is latched, then applied into the result register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (!o_out_valid || i_out_ready) |=> ##1 o_out_valid)
        else $error("result beat missing after request");

    // a target is only reported in resolution-degrading modes, where fps is open
    a_target_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_target_valid |-> o_max_fps == FPS_UNLIM)
        else $error("target reported together with an fps cap");

endmodule

// ----- src/vda_ctrl.sv -----
// Controller for the video degradation adapter: two-state sequencer and
// result valid flag. Depends on vda_pkg.
module vda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output vda_pkg::t_dp_cmd o_cmd
);
    import vda_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.apply = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_APPLY: begin
                o_cmd.apply = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/vda_datapath.sv -----
// Datapath for the video degradation adapter: request latch, scaling
// products, step counters, sink limits and result register. Depends on vda_pkg.
module vda_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vda_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_cfg_we,
    input  logic [vda_pkg::MODE_W-1:0]   i_cfg_wdata,
    input  logic                         i_operation,
    input  logic                         i_reason,
    input  logic [vda_pkg::PC_W-1:0]     i_pixel_count,
    input  logic [vda_pkg::FPS_W-1:0]    i_framerate_fps,
    output logic                         o_acted,
    output logic [vda_pkg::PIX_W-1:0]    o_max_pixels,
    output logic [vda_pkg::PIX_W-1:0]    o_target_pixels,
    output logic                         o_target_valid,
    output logic [vda_pkg::LFPS_W-1:0]   o_max_fps,
    output logic [vda_pkg::STEPS_W-1:0]  o_quality_steps,
    output logic [vda_pkg::STEPS_W-1:0]  o_cpu_steps
);
    import vda_pkg::*;

    // Latched request and products
    logic              r_op;
    logic              r_reason;
    logic [PC_W-1:0]   r_pc;
    logic [FPS_W-1:0]  r_fps;
    logic [PC_W-1:0]   r_dn_px;    // pc*3/5
    logic [PC_W:0]     r_up_px;    // pc*5/3
    logic [FPS_W-1:0]  r_dn_fps;   // fps*2/3
    logic [FPS_W:0]    r_up_fps;   // fps*3/2

    logic [47:0]       prod_dn_px;
    logic [48:0]       prod_up_px;
    logic [17:0]       prod_dn_fps;
    logic [FPS_W+1:0]  fps_x3;

    // Adapter state
    logic [MODE_W-1:0] r_mode;
    logic [MODE_W-1:0] n_mode;
    t_step_pair        r_steps [NUM_MODES];
    t_step_pair        n_pair;
    logic              r_last_valid;
    logic              n_last_valid;
    logic              r_last_up;
    logic              n_last_up;
    logic [PC_W-1:0]   r_last_pc;
    logic [PC_W-1:0]   n_last_pc;
    logic [PIX_W-1:0]  r_limit_px;
    logic [PIX_W-1:0]  n_limit_px;
    logic [PIX_W-1:0]  r_goal_px;
    logic [PIX_W-1:0]  n_goal_px;
    logic              r_goal_set;
    logic              n_goal_set;
    logic [LFPS_W-1:0] r_limit_fps;
    logic [LFPS_W-1:0] n_limit_fps;

    // Result register
    logic              r_acted;
    logic [PIX_W-1:0]  r_max_px;
    logic [PIX_W-1:0]  r_tgt_px;
    logic              r_tgt_valid;
    logic [LFPS_W-1:0] r_max_fps;
    logic [STEPS_W-1:0] r_q_steps;
    logic [STEPS_W-1:0] r_c_steps;

    t_step_pair         cur;
    logic [STEPS_W-1:0] cnt;
    logic [STEPS_W-1:0] other;
    logic [STEPS_W-1:0] new_cnt;
    logic [STEPS_W-1:0] cap;
    logic               is_res;
    logic               prev_down;
    logic               ignore;
    logic               acted;
    logic               res_tv;
    logic [FPS_W-1:0]   fps_floor;

    assign prod_dn_px  = 48'(i_pixel_count) * 48'(K_PIX_3_5);
    assign prod_up_px  = 49'(i_pixel_count) * 49'(K_PIX_5_3);
    assign prod_dn_fps = 18'(i_framerate_fps) * 18'(K_FPS_2_3);
    assign fps_x3      = {2'b00, i_framerate_fps} + {1'b0, i_framerate_fps, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_reason <= i_reason;
            r_pc     <= i_pixel_count;
            r_fps    <= i_framerate_fps;
            r_dn_px  <= prod_dn_px[RECIP_SHIFT+PC_W-1:RECIP_SHIFT];
            r_up_px  <= prod_up_px[RECIP_SHIFT+PC_W:RECIP_SHIFT];
            r_dn_fps <= prod_dn_fps[FPS_SHIFT+FPS_W-1:FPS_SHIFT];
            r_up_fps <= fps_x3[FPS_W+1:1];
        end
    end

    always_comb begin
        cur       = r_steps[r_mode];
        cnt       = (r_reason == REASON_CPU) ? cur.cpu : cur.quality;
        other     = (r_reason == REASON_CPU) ? cur.quality : cur.cpu;
        is_res    = (r_mode == MODE_FRAMERATE) || (r_mode == MODE_BALANCED);
        prev_down = r_last_valid && !r_last_up;
        cap       = is_res ? MAX_RES_DOWNGRADES : MAX_FPS_DOWNGRADES;
        fps_floor = (r_dn_fps < MIN_FPS) ? MIN_FPS : r_dn_fps;

        n_mode       = r_mode;
        n_last_valid = r_last_valid;
        n_last_up    = r_last_up;
        n_last_pc    = r_last_pc;
        n_limit_px   = r_limit_px;
        n_goal_px    = r_goal_px;
        n_goal_set   = r_goal_set;
        n_limit_fps  = r_limit_fps;
        new_cnt      = cnt;
        ignore       = 1'b1;
        acted        = 1'b0;

        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
            if (i_cfg_wdata != r_mode) begin
                n_last_valid = 1'b0;
            end
        end

        if (i_cmd.apply) begin
            if (r_op == OP_DOWN) begin
                if (r_mode == MODE_DISABLED) begin
                    ignore = 1'b1;
                end else if (is_res) begin
                    ignore = prev_down && (r_pc >= r_last_pc);
                end else begin
                    ignore = (r_fps == '0) || (prev_down && (r_fps < MIN_FPS));
                end
                if (!ignore) begin
                    n_last_valid = 1'b1;
                    n_last_up    = 1'b0;
                    n_last_pc    = r_pc;
                end
                // cpu downgrades at the cap still count as the last request
                acted = !ignore && !((r_reason == REASON_CPU) && (cnt >= cap));
                if (acted) begin
                    if (cnt != STEPS_FULL) begin
                        new_cnt = cnt + STEPS_W'(1);
                    end
                    if (is_res) begin
                        if (r_dn_px >= MIN_PIXELS) begin
                            n_limit_px = {2'b00, r_dn_px};
                            n_goal_set = 1'b0;
                            n_goal_px  = '0;
                        end
                    end else begin
                        n_limit_fps = {2'b00, fps_floor};
                    end
                end
            end else begin
                ignore = (cnt == '0) || (r_mode == MODE_DISABLED) ||
                         (is_res && r_last_valid && r_last_up && (r_pc <= r_last_pc));
                acted  = !ignore;
                if (acted) begin
                    n_last_valid = 1'b1;
                    n_last_up    = 1'b1;
                    n_last_pc    = r_pc;
                    new_cnt      = cnt - STEPS_W'(1);
                    // both counters of the mode back at zero lifts its limits
                    if (is_res) begin
                        if ((new_cnt == '0) && (other == '0)) begin
                            n_goal_set = 1'b0;
                            n_goal_px  = '0;
                            n_limit_px = PIX_UNLIM;
                        end else begin
                            n_goal_set = 1'b1;
                            n_goal_px  = {1'b0, r_up_px};
                            n_limit_px = {r_pc, 2'b00};
                        end
                    end else begin
                        if ((new_cnt == '0) && (other == '0)) begin
                            n_limit_fps = FPS_UNLIM;
                        end else begin
                            n_limit_fps = {1'b0, r_up_fps};
                        end
                    end
                end
            end
        end

        n_pair = cur;
        if (r_reason == REASON_CPU) begin
            n_pair.cpu = new_cnt;
        end else begin
            n_pair.quality = new_cnt;
        end
        res_tv = is_res && n_goal_set;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_DISABLED;
            r_last_valid <= 1'b0;
            r_last_up    <= 1'b0;
            r_last_pc    <= '0;
            r_limit_px   <= PIX_UNLIM;
            r_goal_px    <= '0;
            r_goal_set   <= 1'b0;
            r_limit_fps  <= FPS_UNLIM;
            for (int i = 0; i < NUM_MODES; i++) begin
                r_steps[i] <= '0;
            end
        end else begin
            r_mode       <= n_mode;
            r_last_valid <= n_last_valid;
            r_last_up    <= n_last_up;
            r_last_pc    <= n_last_pc;
            r_limit_px   <= n_limit_px;
            r_goal_px    <= n_goal_px;
            r_goal_set   <= n_goal_set;
            r_limit_fps  <= n_limit_fps;
            if (i_cmd.apply) begin
                r_steps[r_mode] <= n_pair;
            end
        end
    end

    // Result beat, masked by the current mode
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_acted     <= acted;
            r_max_px    <= is_res ? n_limit_px : PIX_UNLIM;
            r_tgt_valid <= res_tv;
            r_tgt_px    <= res_tv ? n_goal_px : '0;
            r_max_fps   <= (r_mode == MODE_RESOLUTION) ? n_limit_fps : FPS_UNLIM;
            r_q_steps   <= n_pair.quality;
            r_c_steps   <= n_pair.cpu;
        end
    end

    assign o_acted         = r_acted;
    assign o_max_pixels    = r_max_px;
    assign o_target_pixels = r_tgt_px;
    assign o_target_valid  = r_tgt_valid;
    assign o_max_fps       = r_max_fps;
    assign o_quality_steps = r_q_steps;
    assign o_cpu_steps     = r_c_steps;

endmodule
